// ----- hw/rtl/bq3_pkg.sv -----
package bq3_pkg;

  // Lane and store geometry.
  localparam int LANE_COUNT = 32;
  localparam int LANE_W     = $clog2(LANE_COUNT);
  localparam int ACT_DEPTH  = 512;
  localparam int ACT_AW     = $clog2(ACT_DEPTH);
  localparam int ACT_W      = 64;
  localparam int BLK_W      = 6;
  localparam int PAIR_W     = LANE_W - 1;

  // Input stream packing, lowest bit first.
  localparam int IN_DATA_W   = 192;
  localparam int OFS_AIDX    = 0;
  localparam int OFS_AWORD   = OFS_AIDX + ACT_AW;
  localparam int OFS_BLK     = OFS_AWORD + ACT_W;
  localparam int OFS_P0      = OFS_BLK + BLK_W;
  localparam int OFS_P1      = OFS_P0 + LANE_COUNT;
  localparam int OFS_P2      = OFS_P1 + LANE_COUNT;
  localparam int OFS_SCALE   = OFS_P2 + LANE_COUNT;

  // Operation codes carried in tuser.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_WEIGHT = 1'b1;

  // Default quiet NaN produced by invalid operations.
  localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_MULQ,
    ST_WAITQ,
    ST_MULA,
    ST_WAITA,
    ST_ADD,
    ST_WAITADD,
    ST_TRD_L,
    ST_TRD_R,
    ST_TADD,
    ST_TWAIT,
    ST_EMIT
  } ctrl_state_t;

  typedef enum logic {
    FPU_MUL,
    FPU_ADD
  } fpu_op_t;

  typedef enum logic [1:0] {
    SEL_QS,
    SEL_WA,
    SEL_ACC,
    SEL_TREE
  } opnd_sel_t;

  typedef struct packed {
    logic      load_wr;
    logic      item_take;
    logic      lane_rd;
    logic      lane_next;
    logic      fpu_start;
    opnd_sel_t fpu_sel;
    logic      acc_wr_lane;
    logic      tree_init;
    logic      tree_rd_left;
    logic      tree_rd_right;
    logic      latch_left;
    logic      acc_wr_tree;
    logic      tree_next;
    logic      emit;
  } dp_cmd_t;

  typedef struct packed {
    logic fpu_done;
    logic lane_last;
    logic row_last;
    logic tree_final;
    logic out_busy;
  } dp_status_t;

  // fp32 value of the 3-bit code p0 + 2*p1 - 4*p2.
  function automatic logic [31:0] code_to_f32(input logic p0, input logic p1, input logic p2);
    logic [31:0] r;
    case ({p2, p1, p0})
      3'b000:  r = 32'h0000_0000;
      3'b001:  r = 32'h3F80_0000;
      3'b010:  r = 32'h4000_0000;
      3'b011:  r = 32'h4040_0000;
      3'b100:  r = 32'hC080_0000;
      3'b101:  r = 32'hC040_0000;
      3'b110:  r = 32'hC000_0000;
      3'b111:  r = 32'hBF80_0000;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

  // Round fp32 bits to bf16, nearest even; NaNs keep their top bits and turn quiet.
  function automatic logic [15:0] bf16_round(input logic [31:0] f);
    logic [31:0] s;
    logic [15:0] r;
    s = f + 32'h0000_7FFF + {31'd0, f[16]};
    if ((f[30:23] == 8'hFF) && (f[22:0] != 23'd0)) begin
      r = f[31:16] | 16'h0040;
    end else begin
      r = s[31:16];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/bq3_ram.sv -----
module bq3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port and one registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/bq3_fpu.sv -----
module bq3_fpu (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  bq3_pkg::fpu_op_t op,
  input  logic [31:0]      opa,
  input  logic [31:0]      opb,
  output logic             done,
  output logic [31:0]      result
);

  // Operand unpacking.
  logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;

  always_comb begin
    sa     = opa[31];
    sb     = opb[31];
    a_nan  = (opa[30:23] == 8'hFF) && (opa[22:0] != 23'd0);
    b_nan  = (opb[30:23] == 8'hFF) && (opb[22:0] != 23'd0);
    a_inf  = (opa[30:23] == 8'hFF) && (opa[22:0] == 23'd0);
    b_inf  = (opb[30:23] == 8'hFF) && (opb[22:0] == 23'd0);
    a_zero = (opa[30:0] == 31'd0);
    b_zero = (opb[30:0] == 31'd0);
    ea     = (opa[30:23] == 8'd0) ? 8'd1 : opa[30:23];
    eb     = (opb[30:23] == 8'd0) ? 8'd1 : opb[30:23];
    ma     = {(opa[30:23] != 8'd0), opa[22:0]};
    mb     = {(opb[30:23] != 8'd0), opb[22:0]};
  end

  // First stage: specials, mantissa product or aligned sum.
  logic               s1_spec_nxt, s1_sign_nxt, s1_zsign_nxt;
  logic [31:0]        s1_sbits_nxt;
  logic [47:0]        s1_mag_nxt;
  logic signed [10:0] s1_x_nxt;
  logic               a_big;
  logic [7:0]         e_big, e_small, exp_diff;
  logic [23:0]        m_big, m_small;
  logic [47:0]        big_full, small_full, small_sh;
  logic               small_st;

  always_comb begin
    a_big      = (opa[30:0] >= opb[30:0]);
    e_big      = a_big ? ea : eb;
    e_small    = a_big ? eb : ea;
    m_big      = a_big ? ma : mb;
    m_small    = a_big ? mb : ma;
    exp_diff   = e_big - e_small;
    big_full   = {1'b0, m_big, 23'd0};
    small_full = {1'b0, m_small, 23'd0};
    if (exp_diff >= 8'd48) begin
      small_sh = 48'd0;
      small_st = (m_small != 24'd0);
    end else begin
      small_sh = small_full >> exp_diff;
      small_st = ((small_full & ((48'd1 << exp_diff) - 48'd1)) != 48'd0);
    end

    s1_spec_nxt  = 1'b0;
    s1_sbits_nxt = 32'd0;
    if (op == bq3_pkg::FPU_MUL) begin
      s1_sign_nxt  = sa ^ sb;
      s1_zsign_nxt = sa ^ sb;
      s1_mag_nxt   = ma * mb;
      s1_x_nxt     = $signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd300;
      if (a_nan) begin
        s1_spec_nxt  = 1'b1;
        s1_sbits_nxt = opa | 32'h0040_0000;
      end else if (b_nan) begin
        s1_spec_nxt  = 1'b1;
        s1_sbits_nxt = opb | 32'h0040_0000;
      end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
        s1_spec_nxt  = 1'b1;
        s1_sbits_nxt = bq3_pkg::QNAN_DEFAULT;
      end else if (a_inf || b_inf) begin
        s1_spec_nxt  = 1'b1;
        s1_sbits_nxt = {sa ^ sb, 31'h7F80_0000};
      end
    end else begin
      s1_sign_nxt  = a_big ? sa : sb;
      s1_zsign_nxt = (sa == sb) ? sa : 1'b0;
      if (sa != sb) begin
        s1_mag_nxt = big_full - (small_sh | {47'd0, small_st});
      end else begin
        s1_mag_nxt = big_full + (small_sh | {47'd0, small_st});
      end
      s1_x_nxt = $signed({3'd0, e_big}) - 11'sd173;
      if (a_nan) begin
        s1_spec_nxt  = 1'b1;
        s1_sbits_nxt = opa | 32'h0040_0000;
      end else if (b_nan) begin
        s1_spec_nxt  = 1'b1;
        s1_sbits_nxt = opb | 32'h0040_0000;
      end else if (a_inf && b_inf && (sa != sb)) begin
        s1_spec_nxt  = 1'b1;
        s1_sbits_nxt = bq3_pkg::QNAN_DEFAULT;
      end else if (a_inf) begin
        s1_spec_nxt  = 1'b1;
        s1_sbits_nxt = opa;
      end else if (b_inf) begin
        s1_spec_nxt  = 1'b1;
        s1_sbits_nxt = opb;
      end
    end
  end

  logic               s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic               s1_spec_r, s1_sign_r, s1_zsign_r;
  logic [31:0]        s1_sbits_r;
  logic [47:0]        s1_mag_r;
  logic signed [10:0] s1_x_r;

  // Valid bits travel with the operation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s1_spec_r  <= s1_spec_nxt;
      s1_sbits_r <= s1_sbits_nxt;
      s1_sign_r  <= s1_sign_nxt;
      s1_zsign_r <= s1_zsign_nxt;
      s1_mag_r   <= s1_mag_nxt;
      s1_x_r     <= s1_x_nxt;
    end
  end

  // Second stage: leading zero count.
  logic [5:0] lz_nxt;
  always_comb begin
    lz_nxt = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (s1_mag_r[i]) begin
        lz_nxt = 6'(47 - i);
      end
    end
  end

  logic               s2_spec_r, s2_sign_r, s2_zsign_r, s2_zero_r;
  logic [31:0]        s2_sbits_r;
  logic [47:0]        s2_mag_r;
  logic signed [10:0] s2_x_r;
  logic [5:0]         s2_lz_r;

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      s2_spec_r  <= s1_spec_r;
      s2_sbits_r <= s1_sbits_r;
      s2_sign_r  <= s1_sign_r;
      s2_zsign_r <= s1_zsign_r;
      s2_zero_r  <= (s1_mag_r == 48'd0);
      s2_mag_r   <= s1_mag_r;
      s2_x_r     <= s1_x_r;
      s2_lz_r    <= lz_nxt;
    end
  end

  // Third stage: normalize, then denormalize below the smallest normal exponent.
  logic [47:0]        norm, den;
  logic signed [10:0] bexp0, rsh;
  logic [23:0]        sig_nxt;
  logic               g_nxt, st_nxt, ovf_nxt;
  logic [7:0]         fld_nxt;

  always_comb begin
    norm    = s2_mag_r << s2_lz_r;
    bexp0   = s2_x_r + 11'sd174 - $signed({5'd0, s2_lz_r});
    rsh     = 11'sd1 - bexp0;
    ovf_nxt = (bexp0 > 11'sd254);
    den     = 48'd0;
    if (bexp0 >= 11'sd1) begin
      sig_nxt = norm[47:24];
      g_nxt   = norm[23];
      st_nxt  = (norm[22:0] != 23'd0);
      fld_nxt = bexp0[7:0];
    end else if (rsh >= 11'sd48) begin
      sig_nxt = 24'd0;
      g_nxt   = 1'b0;
      st_nxt  = (norm != 48'd0);
      fld_nxt = 8'd0;
    end else begin
      den     = norm >> rsh[5:0];
      sig_nxt = den[47:24];
      g_nxt   = den[23];
      st_nxt  = (den[22:0] != 23'd0) ||
                ((norm & ((48'd1 << rsh[5:0]) - 48'd1)) != 48'd0);
      fld_nxt = 8'd0;
    end
  end

  logic        s3_spec_r, s3_sign_r, s3_zsign_r, s3_zero_r, s3_g_r, s3_st_r, s3_ovf_r;
  logic [31:0] s3_sbits_r;
  logic [23:0] s3_sig_r;
  logic [7:0]  s3_fld_r;

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      s3_spec_r  <= s2_spec_r;
      s3_sbits_r <= s2_sbits_r;
      s3_sign_r  <= s2_sign_r;
      s3_zsign_r <= s2_zsign_r;
      s3_zero_r  <= s2_zero_r;
      s3_sig_r   <= sig_nxt;
      s3_g_r     <= g_nxt;
      s3_st_r    <= st_nxt;
      s3_ovf_r   <= ovf_nxt;
      s3_fld_r   <= fld_nxt;
    end
  end

  // Fourth stage: round to nearest even and pack.
  logic [30:0] packed_sum;
  logic [31:0] res_nxt;
  always_comb begin
    packed_sum = {s3_fld_r, s3_sig_r[22:0]} +
                 {30'd0, s3_g_r & (s3_st_r | s3_sig_r[0])};
    if (s3_spec_r) begin
      res_nxt = s3_sbits_r;
    end else if (s3_zero_r) begin
      res_nxt = {s3_zsign_r, 31'd0};
    end else if (s3_ovf_r) begin
      res_nxt = {s3_sign_r, 31'h7F80_0000};
    end else begin
      res_nxt = {s3_sign_r, packed_sum};
    end
  end

  logic [31:0] result_r;
  always_ff @(posedge clk) begin
    if (s3_vld_r) begin
      result_r <= res_nxt;
    end
  end

  assign done   = s4_vld_r;
  assign result = result_r;

`ifndef SYNTHESIS
  // A new operation is only issued once the previous one has left the pipe.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !(s1_vld_r || s2_vld_r || s3_vld_r))
    else $error("fpu started while busy");
`endif

endmodule

// ----- hw/rtl/bq3_ctrl.sv -----
module bq3_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_op,
  output logic                in_tready,
  input  bq3_pkg::dp_status_t status,
  output bq3_pkg::dp_cmd_t    cmd
);

  bq3_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bq3_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bq3_pkg::ST_IDLE: begin
        if (in_tvalid && (in_op == bq3_pkg::OP_WEIGHT)) begin
          state_nxt = bq3_pkg::ST_RD;
        end
      end
      bq3_pkg::ST_RD:    state_nxt = bq3_pkg::ST_MULQ;
      bq3_pkg::ST_MULQ:  state_nxt = bq3_pkg::ST_WAITQ;
      bq3_pkg::ST_WAITQ: begin
        if (status.fpu_done) begin
          state_nxt = bq3_pkg::ST_MULA;
        end
      end
      bq3_pkg::ST_MULA:  state_nxt = bq3_pkg::ST_WAITA;
      bq3_pkg::ST_WAITA: begin
        if (status.fpu_done) begin
          state_nxt = bq3_pkg::ST_ADD;
        end
      end
      bq3_pkg::ST_ADD:   state_nxt = bq3_pkg::ST_WAITADD;
      bq3_pkg::ST_WAITADD: begin
        if (status.fpu_done) begin
          if (!status.lane_last) begin
            state_nxt = bq3_pkg::ST_RD;
          end else if (status.row_last) begin
            state_nxt = bq3_pkg::ST_TRD_L;
          end else begin
            state_nxt = bq3_pkg::ST_IDLE;
          end
        end
      end
      bq3_pkg::ST_TRD_L: state_nxt = bq3_pkg::ST_TRD_R;
      bq3_pkg::ST_TRD_R: state_nxt = bq3_pkg::ST_TADD;
      bq3_pkg::ST_TADD:  state_nxt = bq3_pkg::ST_TWAIT;
      bq3_pkg::ST_TWAIT: begin
        if (status.fpu_done) begin
          state_nxt = status.tree_final ? bq3_pkg::ST_EMIT : bq3_pkg::ST_TRD_L;
        end
      end
      bq3_pkg::ST_EMIT: begin
        if (!status.out_busy) begin
          state_nxt = bq3_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bq3_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd       = '0;
    cmd.fpu_sel = bq3_pkg::SEL_QS;
    in_tready = 1'b0;
    case (state_r)
      bq3_pkg::ST_IDLE: begin
        in_tready     = 1'b1;
        cmd.load_wr   = in_tvalid && (in_op == bq3_pkg::OP_LOAD);
        cmd.item_take = in_tvalid && (in_op == bq3_pkg::OP_WEIGHT);
      end
      bq3_pkg::ST_RD:   cmd.lane_rd = 1'b1;
      bq3_pkg::ST_MULQ: begin
        cmd.fpu_start = 1'b1;
        cmd.fpu_sel   = bq3_pkg::SEL_QS;
      end
      bq3_pkg::ST_MULA: begin
        cmd.fpu_start = 1'b1;
        cmd.fpu_sel   = bq3_pkg::SEL_WA;
      end
      bq3_pkg::ST_ADD: begin
        cmd.fpu_start = 1'b1;
        cmd.fpu_sel   = bq3_pkg::SEL_ACC;
      end
      bq3_pkg::ST_WAITADD: begin
        cmd.acc_wr_lane = status.fpu_done;
        cmd.lane_next   = status.fpu_done && !status.lane_last;
        cmd.tree_init   = status.fpu_done && status.lane_last && status.row_last;
      end
      bq3_pkg::ST_TRD_L: cmd.tree_rd_left = 1'b1;
      bq3_pkg::ST_TRD_R: begin
        cmd.tree_rd_right = 1'b1;
        cmd.latch_left    = 1'b1;
      end
      bq3_pkg::ST_TADD: begin
        cmd.fpu_start = 1'b1;
        cmd.fpu_sel   = bq3_pkg::SEL_TREE;
      end
      bq3_pkg::ST_TWAIT: begin
        cmd.acc_wr_tree = status.fpu_done && !status.tree_final;
        cmd.tree_next   = status.fpu_done && !status.tree_final;
      end
      bq3_pkg::ST_EMIT: cmd.emit = !status.out_busy;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/bq3_datapath.sv -----
module bq3_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [bq3_pkg::IN_DATA_W-1:0]       in_data,
  input  logic                                in_last,
  input  bq3_pkg::dp_cmd_t                    cmd,
  output bq3_pkg::dp_status_t                 status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [31:0]                         out_data
);

  localparam int LW = bq3_pkg::LANE_W;
  localparam int PW = bq3_pkg::PAIR_W;

  // Fields of the weight item, held while its lanes are worked through.
  logic [bq3_pkg::BLK_W-1:0]      blk_r;
  logic [bq3_pkg::LANE_COUNT-1:0] p0_r, p1_r, p2_r;
  logic [15:0]                    scale_r;
  logic                           last_r;

  always_ff @(posedge clk) begin
    if (cmd.item_take) begin
      blk_r   <= in_data[bq3_pkg::OFS_BLK +: bq3_pkg::BLK_W];
      p0_r    <= in_data[bq3_pkg::OFS_P0 +: bq3_pkg::LANE_COUNT];
      p1_r    <= in_data[bq3_pkg::OFS_P1 +: bq3_pkg::LANE_COUNT];
      p2_r    <= in_data[bq3_pkg::OFS_P2 +: bq3_pkg::LANE_COUNT];
      scale_r <= in_data[bq3_pkg::OFS_SCALE +: 16];
      last_r  <= in_last;
    end
  end

  // Lane counter and reduction tree position.
  logic [LW-1:0] lane_r, lane_nxt;
  logic [PW-1:0] pair_r, pair_nxt;
  logic [LW-1:0] half_r, half_nxt;

  always_comb begin
    lane_nxt = lane_r;
    if (cmd.item_take) begin
      lane_nxt = '0;
    end else if (cmd.lane_next) begin
      lane_nxt = lane_r + 1'b1;
    end
    pair_nxt = pair_r;
    half_nxt = half_r;
    if (cmd.tree_init) begin
      pair_nxt = '0;
      half_nxt = LW'(bq3_pkg::LANE_COUNT / 2);
    end else if (cmd.tree_next) begin
      if ({1'b0, pair_r} == half_r - 1'b1) begin
        pair_nxt = '0;
        half_nxt = half_r >> 1;
      end else begin
        pair_nxt = pair_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r <= '0;
      pair_r <= '0;
      half_r <= '0;
    end else begin
      lane_r <= lane_nxt;
      pair_r <= pair_nxt;
      half_r <= half_nxt;
    end
  end

  // Activation store.
  logic [bq3_pkg::ACT_W-1:0] act_rdata;

  bq3_ram #(
    .WIDTH (bq3_pkg::ACT_W),
    .DEPTH (bq3_pkg::ACT_DEPTH)
  ) u_act_ram (
    .clk     (clk),
    .wr_en   (cmd.load_wr),
    .wr_addr (in_data[bq3_pkg::OFS_AIDX +: bq3_pkg::ACT_AW]),
    .wr_data (in_data[bq3_pkg::OFS_AWORD +: bq3_pkg::ACT_W]),
    .rd_en   (cmd.lane_rd),
    .rd_addr ({blk_r, lane_r[LW-1:2]}),
    .rd_data (act_rdata)
  );

  logic [15:0] act_bf;
  assign act_bf = act_rdata[{lane_r[1:0], 4'b0000} +: 16];

  // Lane accumulators; an entry without its valid bit reads as +0.0.
  logic [31:0]                    acc_rdata, fpu_result;
  logic [bq3_pkg::LANE_COUNT-1:0] acc_vld_r;
  logic                           acc_rvld_r;
  logic                           acc_rd_en, acc_wr_en;
  logic [LW-1:0]                  acc_raddr, acc_waddr;
  logic [31:0]                    acc_val;

  always_comb begin
    acc_rd_en = cmd.lane_rd || cmd.tree_rd_left || cmd.tree_rd_right;
    acc_raddr = lane_r;
    if (cmd.tree_rd_left) begin
      acc_raddr = {pair_r, 1'b0};
    end else if (cmd.tree_rd_right) begin
      acc_raddr = {pair_r, 1'b1};
    end
    acc_wr_en = cmd.acc_wr_lane || cmd.acc_wr_tree;
    acc_waddr = cmd.acc_wr_tree ? {1'b0, pair_r} : lane_r;
    acc_val   = acc_rvld_r ? acc_rdata : 32'd0;
  end

  bq3_ram #(
    .WIDTH (32),
    .DEPTH (bq3_pkg::LANE_COUNT)
  ) u_acc_ram (
    .clk     (clk),
    .wr_en   (acc_wr_en),
    .wr_addr (acc_waddr),
    .wr_data (fpu_result),
    .rd_en   (acc_rd_en),
    .rd_addr (acc_raddr),
    .rd_data (acc_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= '0;
    end else if (cmd.emit) begin
      acc_vld_r <= '0;
    end else if (acc_wr_en) begin
      acc_vld_r[acc_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_rd_en) begin
      acc_rvld_r <= acc_vld_r[acc_raddr];
    end
  end

  // Left partial sum of a tree pair.
  logic [31:0] left_r;
  always_ff @(posedge clk) begin
    if (cmd.latch_left) begin
      left_r <= acc_val;
    end
  end

  // Operand selection for the shared floating-point unit.
  bq3_pkg::fpu_op_t fpu_op;
  logic [31:0]      fpu_a, fpu_b;

  always_comb begin
    case (cmd.fpu_sel)
      bq3_pkg::SEL_QS: begin
        fpu_op = bq3_pkg::FPU_MUL;
        fpu_a  = bq3_pkg::code_to_f32(p0_r[lane_r], p1_r[lane_r], p2_r[lane_r]);
        fpu_b  = {scale_r, 16'd0};
      end
      bq3_pkg::SEL_WA: begin
        fpu_op = bq3_pkg::FPU_MUL;
        fpu_a  = {bq3_pkg::bf16_round(fpu_result), 16'd0};
        fpu_b  = {act_bf, 16'd0};
      end
      bq3_pkg::SEL_ACC: begin
        fpu_op = bq3_pkg::FPU_ADD;
        fpu_a  = acc_val;
        fpu_b  = fpu_result;
      end
      bq3_pkg::SEL_TREE: begin
        fpu_op = bq3_pkg::FPU_ADD;
        fpu_a  = left_r;
        fpu_b  = acc_val;
      end
      default: begin
        fpu_op = bq3_pkg::FPU_ADD;
        fpu_a  = 32'd0;
        fpu_b  = 32'd0;
      end
    endcase
  end

  logic fpu_done;

  bq3_fpu u_fpu (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.fpu_start),
    .op     (fpu_op),
    .opa    (fpu_a),
    .opb    (fpu_b),
    .done   (fpu_done),
    .result (fpu_result)
  );

  // Output register; it holds the row sum until the transfer completes.
  logic        out_valid_r;
  logic [31:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= fpu_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    status.fpu_done   = fpu_done;
    status.lane_last  = (lane_r == LW'(bq3_pkg::LANE_COUNT - 1));
    status.row_last   = last_r;
    status.tree_final = (half_r == LW'(1));
    status.out_busy   = out_valid_r && !out_ready;
  end

`ifndef SYNTHESIS
  // Lane and tree writes belong to different phases of a row.
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.acc_wr_lane && cmd.acc_wr_tree))
    else $error("two accumulator writers at once");

  // A new row sum never overwrites one that is still waiting.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("row sum overwritten before transfer");

  // After a row is emitted every accumulator reads as zero.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (acc_vld_r == '0))
    else $error("accumulators not cleared after row");
`endif

endmodule

// ----- hw/rtl/bitplane_3bit_quant_gemv_top.sv -----
// Activation load: one transfer per cycle while the controller is idle, no result.
// Weight sub-block: accepted while idle, then its 32 lanes in turn, paced by the shared 4-stage
// floating-point unit that does the scale multiply, activation multiply and add.
// Last sub-block of a row adds 31 tree steps, pairwise adds of the lane sums, and an emit step;
// the row sum then waits in an output register until its transfer completes.
// Reset is synchronous, active low; it clears control state and the accumulator valid bits.
module bitplane_3bit_quant_gemv_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // act_index[8:0], act_word[72:9], block_index[78:73], plane_low[110:79],
  // plane_mid[142:111], plane_high[174:143], group_scale[190:175], zero[191]
  input  logic [bq3_pkg::IN_DATA_W-1:0] in_tdata,
  // operation[0]
  input  logic                          in_tuser,
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // row_result[31:0]
  output logic [31:0]                   out_tdata
);

  bq3_pkg::dp_cmd_t    cmd;
  bq3_pkg::dp_status_t status;

  bq3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  bq3_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_tdata),
    .in_last   (in_tlast),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule
